### rtl/msd_pkg.sv
package msd_pkg;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TEXT = 1'b1;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_DASH  = 8'h2d;
	localparam logic [7:0] CH_STAR  = 8'h2a;

	localparam int WORD_GAP   = 7;
	localparam int LETTER_GAP = 3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_RESOLVE,
		ST_TOKEN,
		ST_LOOK,
		ST_EMIT_TOK,
		ST_EMIT_SP
	} msd_state_t;

	typedef enum logic [1:0] {
		LK_WORD,
		LK_LETTER,
		LK_FINAL
	} msd_kind_t;

	typedef struct packed {
		logic take;
		logic tok_upd;
		logic spoil;
		logic tok_clear;
		logic gap_sub7;
		logic gap_sub3;
		logic gap_clr;
		logic look_start;
		logic emit;
		logic emit_space;
		logic emit_last;
	} msd_cmd_t;

	typedef struct packed {
		logic is_load;
		logic is_space;
		logic is_end;
		logic gap_nz;
		logic gap_ge3;
		logic gap_ge6;
		logic gap_ge7;
		logic gap_ge10;
		logic look_busy;
		logic out_free;
	} msd_status_t;

endpackage

### rtl/morse_stream_decoder.sv
// load words pass IDLE and DISPATCH; a text word with no result does so for a space,
// adds TOKEN for other bytes, and RESOLVE then TOKEN when a short space run spoils it
// a lookup walks the code table one slot a cycle, from slot 0 to a match or the last slot
// each letter or word break runs RESOLVE, LOOK and EMIT_TOK, and EMIT_SP for a word space;
// a message end word gives its result from EMIT_TOK, which waits while the output stalls
// reset clears slot valid bits, token and gap count at once; no clearing pass is needed
module morse_stream_decoder #(
	parameter int TABLE_DEPTH = 64,
	parameter int MAX_SYMBOLS = 8,
	parameter int GAP_MAX     = 63
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// text_char[7:0], entry_slot[13:8], entry_letter[21:14], entry_length[25:22],
	// entry_pattern[33:26], zero fill
	input  logic [39:0] s_tdata,
	input  logic        s_tuser,  // opcode
	input  logic        s_tlast,  // text_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // out_char
	output logic        m_tlast,  // run_last
	output logic        m_tuser   // message_end
);
	import msd_pkg::*;

	msd_cmd_t    cmd;
	msd_status_t status;

	msd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	msd_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.MAX_SYMBOLS (MAX_SYMBOLS),
		.GAP_MAX     (GAP_MAX)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	// a new result never overwrites one still waiting
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> status.out_free)
		else $error("result written over a pending word");

	// a lookup only starts once the previous walk is done
	a_look_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.look_start |-> !status.look_busy)
		else $error("lookup started during a walk");

	// a word break needs a full seven-space run
	a_word_gap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.gap_sub7 |-> status.gap_ge7)
		else $error("word break without enough spaces");

	// no item is taken while a result of the current one is being built
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |-> !status.look_busy)
		else $error("item taken during a table walk");

endmodule

### rtl/msd_ctrl.sv
module msd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  msd_pkg::msd_status_t status,
	output msd_pkg::msd_cmd_t    cmd
);
	import msd_pkg::*;

	msd_state_t state_q, state_d;
	msd_kind_t  kind_q, kind_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q  <= LK_FINAL;
		end else begin
			state_q <= state_d;
			if (cmd.look_start) begin
				kind_q <= kind_d;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (status.is_load) begin
					state_d = ST_IDLE;
				end else if (status.is_space) begin
					state_d = status.is_end ? ST_RESOLVE : ST_IDLE;
				end else begin
					state_d = status.gap_nz ? ST_RESOLVE : ST_TOKEN;
				end
			end
			ST_RESOLVE: begin
				if (status.gap_ge3) begin
					state_d = ST_LOOK;
				end else begin
					state_d = ST_TOKEN;
				end
			end
			ST_TOKEN: begin
				state_d = status.is_end ? ST_LOOK : ST_IDLE;
			end
			ST_LOOK: begin
				if (!status.look_busy) begin
					state_d = ST_EMIT_TOK;
				end
			end
			ST_EMIT_TOK: begin
				if (status.out_free) begin
					case (kind_q)
						LK_WORD:   state_d = ST_EMIT_SP;
						LK_LETTER: state_d = ST_RESOLVE;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_EMIT_SP: begin
				if (status.out_free) begin
					state_d = ST_RESOLVE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd      = '0;
		kind_d   = kind_q;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.take = s_tvalid;
			end
			ST_RESOLVE: begin
				if (status.gap_ge7) begin
					cmd.look_start = 1'b1;
					kind_d         = LK_WORD;
				end else if (status.gap_ge3) begin
					cmd.look_start = 1'b1;
					kind_d         = LK_LETTER;
				end else begin
					// leftover spaces end up inside the next token
					cmd.spoil   = status.gap_nz;
					cmd.gap_clr = 1'b1;
				end
			end
			ST_TOKEN: begin
				cmd.tok_upd = !status.is_space;
				if (status.is_end) begin
					cmd.look_start = 1'b1;
					kind_d         = LK_FINAL;
				end
			end
			ST_EMIT_TOK: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					case (kind_q)
						LK_WORD: begin
							cmd.emit_last = 1'b0;
						end
						LK_LETTER: begin
							cmd.emit_last = !status.is_end && !status.gap_ge6;
							cmd.tok_clear = 1'b1;
							cmd.gap_sub3  = 1'b1;
						end
						default: begin
							cmd.emit_last = 1'b1;
							cmd.tok_clear = 1'b1;
							cmd.gap_clr   = 1'b1;
						end
					endcase
				end
			end
			ST_EMIT_SP: begin
				if (status.out_free) begin
					cmd.emit       = 1'b1;
					cmd.emit_space = 1'b1;
					cmd.emit_last  = !status.is_end && !status.gap_ge10;
					cmd.tok_clear  = 1'b1;
					cmd.gap_sub7   = 1'b1;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

### rtl/msd_dp.sv
module msd_dp #(
	parameter int TABLE_DEPTH = 64,
	parameter int MAX_SYMBOLS = 8,
	parameter int GAP_MAX     = 63
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  msd_pkg::msd_cmd_t    cmd,
	output msd_pkg::msd_status_t status,
	input  logic [39:0]          s_tdata,
	input  logic                 s_tuser,
	input  logic                 s_tlast,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [7:0]           m_tdata,
	output logic                 m_tlast,
	output logic                 m_tuser
);
	import msd_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int GW = $clog2(GAP_MAX + 1);
	localparam int CW = $clog2(MAX_SYMBOLS + 1);

	// input word fields
	logic [7:0] in_char;
	logic [5:0] in_slot;
	logic [7:0] in_letter;
	logic [3:0] in_length;
	logic [7:0] in_pattern;
	assign in_char    = s_tdata[7:0];
	assign in_slot    = s_tdata[13:8];
	assign in_letter  = s_tdata[21:14];
	assign in_length  = s_tdata[25:22];
	assign in_pattern = s_tdata[33:26];

	// code table
	logic [19:0]            mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [8:0]             slot_ext;
	logic [AW-1:0]          wr_addr;
	logic                   wr_en;
	logic [AW-1:0]          rd_addr;
	logic [19:0]            rd_q;
	logic                   rdv_q;

	assign slot_ext = 9'(in_slot);
	assign wr_addr  = slot_ext[AW-1:0];
	assign wr_en    = cmd.take && (s_tuser == OP_LOAD) && (slot_ext < 9'(TABLE_DEPTH));

	// item and token state
	logic                   op_q;
	logic [7:0]             ch_q;
	logic                   end_q;
	logic [GW-1:0]          gap_q;
	logic [MAX_SYMBOLS-1:0] bits_q;
	logic [CW-1:0]          cnt_q;
	logic                   spoil_q;

	// lookup walk
	logic          busy_q;
	logic [AW-1:0] a_q;
	logic [7:0]    result_q;
	logic          match;
	logic [15:0]   mask;
	logic          is_dot, is_dash;

	assign is_dot  = (ch_q == CH_DOT);
	assign is_dash = (ch_q == CH_DASH);

	assign rd_addr = cmd.look_start ? '0 : a_q + 1'b1;
	assign mask    = 16'((17'd1 << cnt_q) - 17'd1);
	assign match   = rdv_q && (5'(rd_q[11:8]) == 5'(cnt_q))
		&& (((16'(rd_q[7:0]) ^ 16'(bits_q)) & mask) == 16'd0);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {in_letter, in_length, in_pattern};
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rdv_q   <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			rdv_q <= valid_q[rd_addr];
		end
	end

	// item latch, gap count and token
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q    <= OP_TEXT;
			ch_q    <= '0;
			end_q   <= 1'b0;
			gap_q   <= '0;
			bits_q  <= '0;
			cnt_q   <= '0;
			spoil_q <= 1'b0;
		end else begin
			if (cmd.take) begin
				op_q <= s_tuser;
			end
			if (cmd.take && (s_tuser == OP_TEXT)) begin
				ch_q  <= in_char;
				end_q <= s_tlast;
				if ((in_char == CH_SPACE) && (9'(gap_q) < 9'(GAP_MAX))) begin
					gap_q <= gap_q + 1'b1;
				end
			end
			if (cmd.gap_sub7) begin
				gap_q <= gap_q - GW'(WORD_GAP);
			end else if (cmd.gap_sub3) begin
				gap_q <= gap_q - GW'(LETTER_GAP);
			end else if (cmd.gap_clr) begin
				gap_q <= '0;
			end
			if (cmd.tok_clear) begin
				bits_q  <= '0;
				cnt_q   <= '0;
				spoil_q <= 1'b0;
			end else if (cmd.spoil) begin
				spoil_q <= 1'b1;
			end else if (cmd.tok_upd) begin
				if ((is_dot || is_dash) && (9'(cnt_q) < 9'(MAX_SYMBOLS))) begin
					if (is_dash) begin
						bits_q <= bits_q | ({{(MAX_SYMBOLS-1){1'b0}}, 1'b1} << cnt_q);
					end
					cnt_q <= cnt_q + 1'b1;
				end else begin
					spoil_q <= 1'b1;
				end
			end
		end
	end

	// table walk, one entry a cycle, lowest matching slot wins
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			a_q      <= '0;
			result_q <= CH_STAR;
		end else begin
			if (cmd.look_start) begin
				a_q    <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				// token may change on the start edge, so empty and spoiled are checked here
				if (spoil_q || (cnt_q == '0)) begin
					result_q <= CH_STAR;
					busy_q   <= 1'b0;
				end else if (match) begin
					result_q <= rd_q[19:12];
					busy_q   <= 1'b0;
				end else if (a_q == AW'(TABLE_DEPTH - 1)) begin
					result_q <= CH_STAR;
					busy_q   <= 1'b0;
				end else begin
					a_q <= a_q + 1'b1;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (cmd.emit) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			m_tdata <= cmd.emit_space ? CH_SPACE : result_q;
			m_tlast <= cmd.emit_last;
			m_tuser <= end_q;
		end
	end

	always_comb begin
		status.is_load   = (op_q == OP_LOAD);
		status.is_space  = (ch_q == CH_SPACE);
		status.is_end    = end_q;
		status.gap_nz    = (gap_q != '0);
		status.gap_ge3   = (9'(gap_q) >= 9'd3);
		status.gap_ge6   = (9'(gap_q) >= 9'd6);
		status.gap_ge7   = (9'(gap_q) >= 9'd7);
		status.gap_ge10  = (9'(gap_q) >= 9'd10);
		status.look_busy = busy_q;
		status.out_free  = !m_tvalid || m_tready;
	end

endmodule

### sim/morse_stream_decoder_tb.sv
module morse_stream_decoder_tb;
	import msd_pkg::*;

	localparam int DEPTH       = 64;
	localparam int MAX_SYM     = 8;
	localparam int GAP_LIMIT   = 63;
	localparam int RANDOM_RUN  = 30;
	localparam int STALL_LIMIT = 5000;
	localparam int TAIL_CYCLES = 200;

	typedef struct {
		logic       op;
		logic [7:0] ch;
		logic       last;
		logic [5:0] slot;
		logic [7:0] letter;
		logic [3:0] len;
		logic [7:0] pat;
		bit         drain;
	} in_word_t;

	typedef struct {
		logic [7:0] ch;
		logic       run_last;
		logic       msg_end;
	} out_char_t;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_COMB
	} rx_mode_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata  = '0;
	logic        s_tuser  = OP_TEXT;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic        m_tuser;

	// decoder shadow: code table plus token and space-run state
	logic        tbl_valid [DEPTH] = '{default: 1'b0};
	logic [7:0]  tbl_letter[DEPTH] = '{default: 8'd0};
	logic [3:0]  tbl_len   [DEPTH] = '{default: 4'd0};
	logic [7:0]  tbl_pat   [DEPTH] = '{default: 8'd0};
	logic [7:0]  tok_bits    = 8'd0;
	int unsigned tok_count   = 0;
	logic        tok_spoiled = 1'b0;
	int unsigned gap_run     = 0;

	// what the stimulus side has loaded, used to build well-formed letters
	bit          book_set[DEPTH] = '{default: 1'b0};
	logic [3:0]  book_len[DEPTH];
	logic [7:0]  book_pat[DEPTH];

	in_word_t  pending[$];
	out_char_t word_chars[$];
	out_char_t due_chars[$];
	in_word_t  cur_word;
	bit        hold_next   = 1'b0;
	int        words_taken = 0;
	int        total_words = 0;
	int        mismatches  = 0;
	int        gap_left    = 0;
	int        burst_left  = 1;
	int        rx_tick     = 0;
	rx_mode_t  rx_mode     = RX_OPEN;
	int        idle_cycles = 0;

	morse_stream_decoder #(
		.TABLE_DEPTH(DEPTH),
		.MAX_SYMBOLS(MAX_SYM),
		.GAP_MAX    (GAP_LIMIT)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ---------------- prediction ----------------

	function automatic logic [7:0] match_token();
		logic [8:0] mask;
		if (tok_spoiled || tok_count == 0)
			return CH_STAR;
		mask = (9'd1 << tok_count) - 9'd1;
		// lowest valid slot with the same length and pattern wins
		for (int i = 0; i < DEPTH; i++) begin
			if (tbl_valid[i] && tbl_len[i] != 4'd0 && tbl_len[i] <= MAX_SYM &&
			    tbl_len[i] == tok_count && ((tbl_pat[i] ^ tok_bits) & mask[7:0]) == 8'd0)
				return tbl_letter[i];
		end
		return CH_STAR;
	endfunction

	task automatic push_char(input logic [7:0] c, input logic msg_end);
		out_char_t r;
		r.ch       = c;
		r.run_last = 1'b0;
		r.msg_end  = msg_end;
		word_chars.insert(word_chars.size(), r);
	endtask

	task automatic clear_token();
		tok_bits    = 8'd0;
		tok_count   = 0;
		tok_spoiled = 1'b0;
	endtask

	// word breaks first, then letter breaks, a leftover space spoils the next token
	task automatic split_gap(input logic msg_end);
		int unsigned word_breaks, rest, letter_breaks;
		word_breaks   = gap_run / WORD_GAP;
		rest          = gap_run % WORD_GAP;
		letter_breaks = rest / LETTER_GAP;
		gap_run       = 0;
		if (word_breaks > 0) begin
			push_char(match_token(), msg_end);
			push_char(CH_SPACE, msg_end);
			for (int i = 1; i < word_breaks; i++) begin
				push_char(CH_STAR, msg_end);
				push_char(CH_SPACE, msg_end);
			end
			clear_token();
		end
		if (letter_breaks > 0) begin
			push_char(match_token(), msg_end);
			for (int i = 1; i < letter_breaks; i++)
				push_char(CH_STAR, msg_end);
			clear_token();
		end
		if (rest % LETTER_GAP != 0)
			tok_spoiled = 1'b1;
	endtask

	task automatic decode_word(input in_word_t w);
		word_chars.delete();
		if (w.op == OP_LOAD) begin
			tbl_valid[w.slot]  = 1'b1;
			tbl_letter[w.slot] = w.letter;
			tbl_len[w.slot]    = w.len;
			tbl_pat[w.slot]    = w.pat;
		end else begin
			if (w.ch == CH_SPACE) begin
				if (gap_run < GAP_LIMIT)
					gap_run++;
				if (w.last)
					split_gap(1'b1);
			end else begin
				if (gap_run > 0)
					split_gap(w.last);
				if (w.ch == CH_DOT || w.ch == CH_DASH) begin
					if (tok_count < MAX_SYM) begin
						if (w.ch == CH_DASH)
							tok_bits[tok_count] = 1'b1;
						tok_count++;
					end else begin
						tok_spoiled = 1'b1;
					end
				end else begin
					tok_spoiled = 1'b1;
				end
			end
			if (w.last) begin
				push_char(match_token(), 1'b1);
				clear_token();
				gap_run = 0;
			end
			if (word_chars.size() > 0)
				word_chars[$].run_last = 1'b1;
			foreach (word_chars[i])
				due_chars.insert(due_chars.size(), word_chars[i]);
		end
	endtask

	// ---------------- stimulus builders ----------------

	task automatic push_word(input in_word_t w);
		w.drain   = hold_next;
		hold_next = 1'b0;
		pending.insert(pending.size(), w);
	endtask

	task automatic add_load(input logic [5:0] slot, input logic [7:0] letter,
	                        input logic [3:0] len, input logic [7:0] pat);
		in_word_t w;
		w.op     = OP_LOAD;
		w.ch     = 8'($urandom);
		w.last   = 1'($urandom);
		w.slot   = slot;
		w.letter = letter;
		w.len    = len;
		w.pat    = pat;
		book_set[slot] = 1'b1;
		book_len[slot] = len;
		book_pat[slot] = pat;
		push_word(w);
	endtask

	task automatic add_text(input logic [7:0] c, input logic last);
		in_word_t w;
		w.op     = OP_TEXT;
		w.ch     = c;
		w.last   = last;
		w.slot   = 6'($urandom);
		w.letter = 8'($urandom);
		w.len    = 4'($urandom);
		w.pat    = 8'($urandom);
		push_word(w);
	endtask

	task automatic add_gap(input int n);
		for (int i = 0; i < n; i++)
			add_text(CH_SPACE, 1'b0);
	endtask

	// mostly a code from the loaded set, now and then a random or overlong symbol run
	task automatic add_letter();
		int         slot;
		int         len;
		logic [8:0] bits;
		slot = -1;
		if ($urandom_range(0, 7) != 0) begin
			for (int t = 0; t < 16 && slot < 0; t++) begin
				int s;
				s = $urandom_range(0, DEPTH - 1);
				if (book_set[s] && book_len[s] >= 1 && book_len[s] <= MAX_SYM)
					slot = s;
			end
		end
		if (slot >= 0) begin
			len  = book_len[slot];
			bits = {1'b0, book_pat[slot]};
		end else begin
			len  = $urandom_range(1, MAX_SYM + 1);
			bits = 9'($urandom);
		end
		for (int k = 0; k < len; k++)
			add_text(bits[k] ? CH_DASH : CH_DOT, 1'b0);
	endtask

	// ---------------- driver ----------------

	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				decode_word(cur_word);
				words_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending.size() == 0 ||
				             (pending[0].drain && due_chars.size() != 0)) begin
					s_tvalid <= 1'b0;
				end else begin
					cur_word = pending.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {6'd0, cur_word.pat, cur_word.len, cur_word.letter,
					             cur_word.slot, cur_word.ch};
					s_tuser  <= cur_word.op;
					s_tlast  <= cur_word.last;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 12);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
					end
				end
			end
		end
	end

	// ---------------- receiver stalls ----------------

	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (rx_tick == 0)
				rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_tick = (rx_tick + 1) % 97;
			case (rx_mode)
				RX_OPEN:   m_tready <= 1'b1;
				RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
				RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
				default:   m_tready <= (rx_tick % 9) >= 5;
			endcase
		end
	end

	// ---------------- monitor ----------------

	always @(posedge clk) begin
		out_char_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (due_chars.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: char %02h last %0b end %0b",
					         m_tdata, m_tlast, m_tuser);
			end else begin
				want = due_chars.pop_front();
				if (m_tdata !== want.ch || m_tlast !== want.run_last ||
				    m_tuser !== want.msg_end) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: want %02h/%0b/%0b got %02h/%0b/%0b",
						         want.ch, want.run_last, want.msg_end,
						         m_tdata, m_tlast, m_tuser);
				end
			end
		end
	end

	// ---------------- watchdog ----------------

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ---------------- sequence ----------------

	initial begin
		int  kind, n, nwords, nletters, random_start;
		bit  broken;
		logic [3:0] len;

		// directed: empty table, table extremes, shadowed slot, dead slots
		add_text(CH_DASH, 1'b1);
		add_load(6'd0, "E", 4'd1, 8'h00);
		add_load(6'd1, "T", 4'd1, 8'h01);
		add_load(6'd2, "A", 4'd2, 8'b10);
		add_load(6'd3, "X", 4'd2, 8'b10);
		add_load(6'd63, 8'hff, 4'd8, 8'hff);
		add_load(6'd5, "Z", 4'd0, 8'h00);
		add_load(6'd6, 8'h00, 4'd15, 8'h00);
		// letter break, word break, then a stray byte ending the message
		hold_next = 1'b1;
		add_text(CH_DOT, 1'b0);
		add_gap(3);
		add_text(CH_DASH, 1'b0);
		add_gap(7);
		add_text(8'hff, 1'b1);
		// lone space ending a message, then a lone other byte
		add_text(CH_SPACE, 1'b1);
		add_text(8'h00, 1'b1);

		// saturated space run followed by a letter
		hold_next = 1'b1;
		add_text(CH_DOT, 1'b0);
		add_gap(GAP_LIMIT + 1 + $urandom_range(0, 6));
		add_letter();
		pending[$].last = 1'b1;

		for (int i = 0; i < 16; i++)
			add_load(6'($urandom), 8'($urandom), 4'($urandom_range(1, MAX_SYM)), 8'($urandom));

		random_start = pending.size();
		hold_next    = 1'b1;
		while (pending.size() < random_start + RANDOM_RUN) begin
			kind = $urandom_range(0, 19);
			if ($urandom_range(0, 24) == 0)
				hold_next = 1'b1;
			if (kind < 3) begin
				len = ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'($urandom_range(1, MAX_SYM));
				add_load(6'($urandom), 8'($urandom), len, 8'($urandom));
			end else if (kind < 5) begin
				// noise: any mix of symbols, spaces and stray bytes
				n = $urandom_range(1, 10);
				for (int i = 0; i < n; i++) begin
					case ($urandom_range(0, 3))
						0:       add_text(CH_DOT, 1'b0);
						1:       add_text(CH_DASH, 1'b0);
						2:       add_text(CH_SPACE, 1'b0);
						default: add_text(8'($urandom), 1'b0);
					endcase
				end
				pending[$].last = 1'b1;
			end else begin
				broken   = ($urandom_range(0, 4) == 0);
				nwords   = $urandom_range(1, 3);
				for (int wd = 0; wd < nwords; wd++) begin
					nletters = $urandom_range(1, 4);
					for (int l = 0; l < nletters; l++) begin
						add_letter();
						if (l != nletters - 1)
							add_gap(broken ? $urandom_range(1, 6) : LETTER_GAP);
					end
					if (wd != nwords - 1)
						add_gap(broken ? $urandom_range(4, 16) :
						        (($urandom_range(0, 4) == 0) ? 2 * WORD_GAP : WORD_GAP));
				end
				if ($urandom_range(0, 4) == 0) begin
					add_gap($urandom_range(0, 8));
					add_text(CH_SPACE, 1'b1);
				end else begin
					pending[$].last = 1'b1;
				end
			end
		end
		total_words = pending.size();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (words_taken != total_words)
			@(posedge clk);
		while (due_chars.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
